>>> hdl/assert_macros.svh
// assertion macros used by ipap_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hdl/ipap_pkg.sv
// types and constants for the ip address text parser
// no dependencies
package ipap_pkg;
    typedef struct packed {
        logic [7:0] chr;
        logic       is_end;
        logic       mode;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic        family;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_COLON1 = 2'd1,
        PH_NORMAL = 2'd2,
        PH_CLOSED = 2'd3
    } t_phase;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
endpackage

>>> hdl/ipap_core.sv
// per-character parse state and end-of-string address assembly
// depends on ipap_pkg and assert_macros.svh
`include "assert_macros.svh"
module ipap_core
    import ipap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_out_item o_result
);
    logic [7:0]   r_bytes [16];
    logic [4:0]   r_wpos, r_gpos;
    logic         r_gseen, r_hseen, r_err, r_dseen, r_tok, r_tail, r_fam;
    logic [15:0]  r_hex;
    t_phase       r_ph;
    logic [7:0]   r_doct;
    logic [2:0]   r_dcnt;
    logic [31:0]  r_v4;

    logic [7:0]   n_bytes [16];
    logic [4:0]   n_wpos, n_gpos;
    logic         n_gseen, n_hseen, n_err, n_dseen, n_tok, n_tail, n_fam;
    logic [15:0]  n_hex;
    t_phase       n_ph;
    logic [7:0]   n_doct;
    logic [2:0]   n_dcnt;
    logic [31:0]  n_v4;
    t_out_item    res;

    // hex digit decode
    function automatic logic [3:0] hexval(input logic [7:0] c, output logic hit);
        hit = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) return c[3:0] - 4'd0;
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return c[3:0] + 4'd9;
        hit = 1'b0;
        return 4'd0;
    endfunction

    logic [7:0]  c;
    logic        is_dig, hhit, dig_ok, dot_ok, skip, v6ok;
    logic [3:0]  hv;
    logic [11:0] prod;
    logic [31:0] v4f;
    logic [7:0]  full [16];
    logic [7:0]  moved [16];
    logic [4:0]  nmov;

    always_comb begin
        c      = i_item.chr;
        is_dig = (c >= 8'h30) && (c <= 8'h39);
        hv     = hexval(c, hhit);
        n_bytes = r_bytes;
        n_wpos = r_wpos; n_gpos = r_gpos; n_gseen = r_gseen; n_hseen = r_hseen;
        n_err = r_err; n_dseen = r_dseen; n_tok = r_tok; n_tail = r_tail;
        n_hex = r_hex; n_ph = r_ph; n_doct = r_doct; n_dcnt = r_dcnt; n_v4 = r_v4;
        n_fam = (r_ph == PH_START) ? i_item.mode : r_fam;
        // decimal digit step
        prod   = {4'd0, r_doct} * 12'd10 + {8'd0, c[3:0]};
        dig_ok = !(r_dseen && r_doct == 8'd0) && prod <= 12'd255
                 && (r_dseen || r_dcnt < 3'd4);
        dot_ok = r_dseen && r_dcnt != 3'd4;
        skip   = 1'b0;
        res    = '0;
        v4f = {r_v4[23:0], r_doct};
        v6ok = 1'b0; nmov = 5'd0;
        full = r_bytes; moved = r_bytes;

        if (!i_item.is_end) begin
            if (!n_fam || r_tail) begin
                if (!n_fam) n_ph = PH_NORMAL;
                if (!r_err) begin
                    if (is_dig && dig_ok) begin
                        n_doct = prod[7:0];
                        if (!r_dseen) begin
                            n_dcnt = r_dcnt + 3'd1; n_dseen = 1'b1;
                        end
                    end else if (c == CH_DOT && dot_ok) begin
                        n_v4 = {r_v4[23:0], r_doct}; n_doct = '0; n_dseen = 1'b0;
                    end else n_err = 1'b1;
                end
            end else if (!r_err) begin
                if (r_ph == PH_START) begin
                    if (c == CH_COLON) begin
                        n_ph = PH_COLON1; skip = 1'b1;
                    end else n_ph = PH_NORMAL;
                end else if (r_ph == PH_COLON1) begin
                    if (c != CH_COLON) n_err = 1'b1;
                    skip = (c != CH_COLON);
                    n_ph = (c != CH_COLON) ? PH_COLON1 : PH_NORMAL;
                end else if (r_ph == PH_CLOSED) n_ph = PH_NORMAL;
                if (!skip) begin
                    if (hhit) begin
                        if (r_hex[15:12] != 4'd0) n_err = 1'b1;
                        else begin
                            n_hex = {r_hex[11:0], hv}; n_hseen = 1'b1;
                            if (r_tok) begin
                                if (is_dig && dig_ok) begin
                                    n_doct = prod[7:0];
                                    if (!r_dseen) begin
                                        n_dcnt = r_dcnt + 3'd1; n_dseen = 1'b1;
                                    end
                                end else n_tok = 1'b0;
                            end
                        end
                    end else if (c == CH_COLON) begin
                        n_doct = '0; n_dcnt = '0; n_dseen = 1'b0; n_tok = 1'b1;
                        n_v4 = '0;
                        if (!r_hseen) begin
                            if (r_gseen) n_err = 1'b1;
                            else begin
                                n_gseen = 1'b1; n_gpos = r_wpos;
                            end
                        end else if (r_wpos > 5'd14) n_err = 1'b1;
                        else begin
                            n_bytes[r_wpos[3:0]] = r_hex[15:8];
                            n_bytes[r_wpos[3:0] + 4'd1] = r_hex[7:0];
                            n_wpos = r_wpos + 5'd2; n_hex = '0; n_hseen = 1'b0;
                            n_ph = PH_CLOSED;
                        end
                    end else if (c == CH_DOT && r_wpos <= 5'd12 && r_tok && dot_ok)
                    begin
                        n_v4 = {r_v4[23:0], r_doct}; n_doct = '0; n_dseen = 1'b0;
                        n_tail = 1'b1; n_hseen = 1'b0;
                    end else n_err = 1'b1;
                end
            end
        end else begin
            res.family = n_fam;
            if (!n_fam) begin
                res.ok = !r_err && r_dcnt == 3'd4;
                if (res.ok) res.address_low = {32'd0, v4f};
            end else begin
                v6ok = !r_err && r_ph != PH_COLON1 && r_ph != PH_CLOSED;
                nmov = r_wpos;
                if (r_tail) begin
                    if (r_dcnt != 3'd4 || r_wpos > 5'd12) v6ok = 1'b0;
                    for (int i = 0; i < 4; i++)
                        full[r_wpos[3:0] + 4'(i)] = v4f[31 - 8*i -: 8];
                    nmov = r_wpos + 5'd4;
                end else if (r_hseen) begin
                    if (r_wpos > 5'd14) v6ok = 1'b0;
                    full[r_wpos[3:0]] = r_hex[15:8];
                    full[r_wpos[3:0] + 4'd1] = r_hex[7:0];
                    nmov = r_wpos + 5'd2;
                end
                moved = full;
                if (r_gseen) begin
                    if (nmov >= 5'd16 || r_gpos > nmov) v6ok = 1'b0;
                    // shift gap tail to the end, zero fill
                    for (int i = 0; i < 16; i++) begin
                        if (5'(i) < r_gpos) moved[i] = full[i];
                        else if (5'(i) >= 5'd16 - (nmov - r_gpos))
                            moved[i] = full[4'(5'(i) - 5'd16 + nmov)];
                        else moved[i] = 8'd0;
                    end
                end else if (nmov != 5'd16) v6ok = 1'b0;
                res.ok = v6ok;
                if (v6ok)
                    for (int i = 0; i < 8; i++) begin
                        res.address_high[63 - 8*i -: 8] = moved[i];
                        res.address_low[63 - 8*i -: 8]  = moved[i + 8];
                    end
            end
            for (int i = 0; i < 16; i++) n_bytes[i] = '0;
            n_wpos = '0; n_gpos = '0; n_gseen = 1'b0; n_hseen = 1'b0; n_err = 1'b0;
            n_dseen = 1'b0; n_tok = 1'b1; n_tail = 1'b0; n_hex = '0; n_ph = PH_START;
            n_doct = '0; n_dcnt = '0; n_v4 = '0; n_fam = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_bytes[i] <= '0;
            r_wpos <= '0; r_gpos <= '0; r_gseen <= 1'b0; r_hseen <= 1'b0;
            r_err <= 1'b0; r_dseen <= 1'b0; r_tok <= 1'b1; r_tail <= 1'b0;
            r_hex <= '0; r_ph <= PH_START; r_doct <= '0; r_dcnt <= '0;
            r_v4 <= '0; r_fam <= 1'b0;
        end else if (i_fire) begin
            r_bytes <= n_bytes;
            r_wpos <= n_wpos; r_gpos <= n_gpos; r_gseen <= n_gseen; r_hseen <= n_hseen;
            r_err <= n_err; r_dseen <= n_dseen; r_tok <= n_tok; r_tail <= n_tail;
            r_hex <= n_hex; r_ph <= n_ph; r_doct <= n_doct; r_dcnt <= n_dcnt;
            r_v4 <= n_v4; r_fam <= n_fam;
        end
    end

    assign o_result = res;

    `ASSERT_IMPL(a_dcnt_range, i_clk, i_rst_n, 1'b1, r_dcnt <= 3'd4)
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_fire && i_item.is_end, r_ph == PH_START && !r_err && r_wpos == 5'd0)
    `ASSERT_IMPL(a_wpos_even, i_clk, i_rst_n, 1'b1, !r_wpos[0] && r_wpos <= 5'd16)
endmodule

>>> hdl/ip_address_text_parser.sv
// ip address text parser: one character per cycle unless stalled, result on the end item
// result: registered as the end item is taken, valid from the next cycle
// throughput: one item per cycle; only an end item is stalled, while a result waits and i_stall is high
// reset: synchronous active low, parse state cleared and output empty
// depends on ipap_pkg and ipap_core
module ip_address_text_parser
    import ipap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);
    logic      r_ovalid;
    t_out_item r_odata;
    t_out_item res;
    logic      fire;

    // stall only an end item that cannot be placed
    assign o_stall = r_ovalid && i_stall && i_data.is_end;
    assign fire    = i_valid && !o_stall;

    ipap_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (i_data),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fire && i_data.is_end) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_data.is_end) begin
            r_odata <= res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
endmodule
